// ----- hw/rtl/csnb_pkg.sv -----
// Package for the source noise blanker: payload structs, lexer mode codes,
// character constants and the per-byte lexer decision function.
// No dependencies.
package csnb_pkg;

   // Character codes the lexer reacts to
   localparam logic [7:0] ChHash   = 8'd35;
   localparam logic [7:0] ChSlash  = 8'd47;
   localparam logic [7:0] ChStar   = 8'd42;
   localparam logic [7:0] ChDquote = 8'd34;
   localparam logic [7:0] ChSquote = 8'd39;
   localparam logic [7:0] ChBslash = 8'd92;
   localparam logic [7:0] ChNl     = 8'd10;
   localparam logic [7:0] ChUnder  = 8'd95;
   localparam logic [7:0] ChSpace  = 8'd32;
   localparam logic [7:0] ChNul    = 8'd0;

   // Output queue sizing: room for the two results one item can cause
   localparam int unsigned RspDepth   = 4;
   localparam int unsigned RspPtrW    = $clog2(RspDepth);
   localparam int unsigned RspCountW  = $clog2(RspDepth + 1);

   typedef enum logic [2:0] {
      MODE_NORMAL  = 3'd0,
      MODE_LINE    = 3'd1,
      MODE_BLOCK   = 3'd2,
      MODE_STRING  = 3'd3,
      MODE_CHAR    = 3'd4,
      MODE_PREPROC = 3'd5
   } lex_mode_type;

   typedef struct packed {
      logic [7:0] source_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [7:0] clean_byte;
      logic       last_byte;
   } rsp_type;

   typedef struct packed {
      lex_mode_type mode;
      logic         line_start;
      logic         skip_next;
      logic         prev_ident;
   } lex_state_type;

   typedef struct packed {
      lex_state_type st;
      logic [7:0]    out_byte;
   } lex_result_type;

   localparam lex_state_type LexReset = '{
      mode:       MODE_NORMAL,
      line_start: 1'b1,
      skip_next:  1'b0,
      prev_ident: 1'b0
   };

   function automatic logic is_ident(logic [7:0] c);
      return (c >= 8'd48 && c <= 8'd57) || (c >= 8'd65 && c <= 8'd90) ||
             (c >= 8'd97 && c <= 8'd122) || c == ChUnder;
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return c == ChSpace || (c >= 8'd9 && c <= 8'd13);
   endfunction

   // Decide byte c with lookahead nx; returns the emitted byte and next state
   function automatic lex_result_type csnb_decide(lex_state_type st, logic [7:0] c,
                                                  logic [7:0] nx);
      lex_result_type r;
      logic ident_before;
      ident_before = st.prev_ident;
      r.st = st;
      r.out_byte = ChSpace;
      r.st.prev_ident = is_ident(c);
      if (st.skip_next) begin
         r.st.skip_next = 1'b0;
      end else begin
         unique case (st.mode)
            MODE_LINE, MODE_PREPROC: begin
               if (c == ChBslash && nx == ChNl) begin
                  r.st.skip_next = 1'b1;
               end else if (c == ChNl) begin
                  r.out_byte = ChNl;
                  r.st.line_start = 1'b1;
                  r.st.mode = MODE_NORMAL;
               end
            end
            MODE_BLOCK: begin
               if (c == ChStar && nx == ChSlash) begin
                  r.st.mode = MODE_NORMAL;
                  r.st.skip_next = 1'b1;
               end else if (c == ChNl) begin
                  r.out_byte = ChNl;
               end
            end
            MODE_STRING: begin
               if (c == ChBslash) begin
                  r.st.skip_next = 1'b1;
               end else if (c == ChDquote) begin
                  r.st.mode = MODE_NORMAL;
               end else if (c == ChNl) begin
                  r.out_byte = ChNl;
               end
            end
            MODE_CHAR: begin
               if (c == ChBslash) begin
                  r.st.skip_next = 1'b1;
               end else if (c == ChSquote) begin
                  r.st.mode = MODE_NORMAL;
               end
            end
            // normal mode, and the unreachable codes behave the same
            default: begin
               if (st.line_start && c == ChHash) begin
                  r.st.mode = MODE_PREPROC;
               end else if (c == ChSlash && nx == ChSlash) begin
                  r.st.mode = MODE_LINE;
                  r.st.skip_next = 1'b1;
               end else if (c == ChSlash && nx == ChStar) begin
                  r.st.mode = MODE_BLOCK;
                  r.st.skip_next = 1'b1;
               end else if (c == ChDquote) begin
                  r.st.mode = MODE_STRING;
               end else if (c == ChSquote && !ident_before) begin
                  r.st.mode = MODE_CHAR;
               end else begin
                  r.out_byte = c;
                  if (c == ChNl) begin
                     r.st.line_start = 1'b1;
                  end else if (!is_space(c)) begin
                     r.st.line_start = 1'b0;
                  end
               end
            end
         endcase
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/c_source_noise_blanker.sv -----
// Source noise blanker top level: byte lexer with one-byte lookahead and a
// small output queue. Depends on csnb_pkg.
//
// Usage:
//   req_ channel carries one source byte per transfer; end_of_text marks the
//   final byte of a text. rsp_ channel returns the cleaned stream, same
//   length, with comments, literals and preprocessor lines turned to spaces
//   and last_byte set on the final byte of each text.
//   Each byte is held until its successor arrives, so a byte's result is
//   queued at the transfer of the next byte. The final byte is decided at
//   once against a NUL lookahead, and when a byte is held its transfer queues
//   two results (held byte and final byte).
//   Throughput: one byte per cycle while req_stall is low; the final byte of a
//   text adds one extra result, drained by the single result port.
//   The queue holds four results; req_stall is high while more than two are
//   waiting, so a stalled receiver backs up into the sender after at most
//   four further transfers.
//   After reset the lexer is in normal mode at line start with nothing held
//   and the queue empty; the same lexer state, with nothing held, returns after every final byte.
module c_source_noise_blanker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  csnb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output csnb_pkg::rsp_type rsp_data
);
   import csnb_pkg::*;

   lex_state_type st_ff, st_in;
   logic [7:0]    held_byte_ff, held_byte_in;
   logic          held_valid_ff, held_valid_in;

   rsp_type                fifo_ff [RspDepth];
   logic [RspPtrW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [RspCountW-1:0]   count_ff, count_in;

   logic           req_xfer, rsp_xfer;
   lex_result_type dec_held, dec_cur;
   lex_state_type  st_mid;
   rsp_type        ent_held, ent_last, ent_first;
   logic [1:0]     push_cnt;
   logic [RspPtrW-1:0] wr_ptr_nxt;

   // Handshakes
   assign req_stall = (count_ff > RspCountW'(RspDepth - 2));
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = (count_ff != '0);
   assign rsp_xfer  = rsp_valid && !rsp_stall;
   assign rsp_data  = fifo_ff[rd_ptr_ff];

   // Decide the held byte, then the current one when it closes the text
   always_comb begin
      dec_held = csnb_decide(st_ff, held_byte_ff, req_data.source_byte);
      st_mid   = held_valid_ff ? dec_held.st : st_ff;
      dec_cur  = csnb_decide(st_mid, req_data.source_byte, ChNul);
      ent_held = '{clean_byte: dec_held.out_byte, last_byte: 1'b0};
      ent_last = '{clean_byte: dec_cur.out_byte, last_byte: 1'b1};
      ent_first = held_valid_ff ? ent_held : ent_last;
      push_cnt = req_xfer ? ({1'b0, held_valid_ff} + {1'b0, req_data.end_of_text}) : 2'd0;
      wr_ptr_nxt = wr_ptr_ff + RspPtrW'(1);
   end

   // Lexer state update
   always_comb begin
      st_in         = st_ff;
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      if (req_xfer) begin
         if (req_data.end_of_text) begin
            st_in         = LexReset;
            held_valid_in = 1'b0;
         end else begin
            st_in         = st_mid;
            held_byte_in  = req_data.source_byte;
            held_valid_in = 1'b1;
         end
      end
   end

   // Queue pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + RspPtrW'(push_cnt);
      rd_ptr_in = rsp_xfer ? rd_ptr_ff + RspPtrW'(1) : rd_ptr_ff;
      count_in  = count_ff + RspCountW'(push_cnt) - RspCountW'(rsp_xfer);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= LexReset;
         held_valid_ff <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         st_ff         <= st_in;
         held_valid_ff <= held_valid_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      held_byte_ff <= held_byte_in;
      if (push_cnt != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= ent_first;
      end
      if (push_cnt == 2'd2) begin
         fifo_ff[wr_ptr_nxt] <= ent_last;
      end
   end

   // Checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RspCountW'(RspDepth))
      else $error("result queue over capacity");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> count_ff == $past(count_ff) + RspCountW'($past(push_cnt))
                                    - RspCountW'($past(rsp_xfer)))
      else $error("result queue count mismatch");

   a_last_flushes: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_data.end_of_text |=> !held_valid_ff && st_ff == LexReset)
      else $error("lexer not returned to start after final byte");

   a_byte_held: assert property (@(posedge clock) disable iff (reset)
      req_xfer && !req_data.end_of_text |=> held_valid_ff &&
                                           held_byte_ff == $past(req_data.source_byte))
      else $error("lookahead byte not held");

endmodule
